// ----- hdl/rcch_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcch_pkg
// shared defaults and types for the capped cylinder / cone hit core
// ----------------------------------------------------------------------------
package rcch_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  // surface codes of a result word
  typedef enum logic [1:0] {
    SURF_SIDE = 2'd0,
    SURF_BASE = 2'd1,
    SURF_TOP  = 2'd2
  } surf_t;

  // classification made by the front end
  typedef struct packed {
    logic side_hit;
    logic den_zero;
    logic cone;
  } rcch_class_t;

  // result flags
  typedef struct packed {
    logic  hit;
    surf_t surface;
  } rcch_flags_t;

endpackage

// ----- hdl/rcch_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcch_fifo
// show-ahead queue: memory plus a registered read stage that holds the head
// ----------------------------------------------------------------------------
module rcch_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              empty
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              head_valid;
  logic              load;

  // refill the head register when it is free or being taken
  assign load  = (count != '0) && (!head_valid || pop);
  assign empty = !head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (load) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(load);
      if (load) begin
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/rcch_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcch_front
// geometry precompute, side-hit classification and cap plane numerators
// ----------------------------------------------------------------------------
module rcch_front
  import rcch_pkg::*;
#(
  parameter int W = DEF_COORD_WIDTH,
  parameter int F = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   in_org [3],
  input  logic signed [W-1:0]   in_head [3],
  input  logic signed [W-1:0]   in_t0,
  input  logic                  in_cone,
  input  logic signed [W-1:0]   base_pt [3],
  input  logic signed [W-1:0]   axis_dir [3],
  input  logic        [W-2:0]   height,
  input  logic        [W-2:0]   radius,
  output logic signed [W-1:0]   top_pt [3],
  output logic        [2*W-3:0] radius_sq,
  output logic                  out_valid,
  output logic signed [W-1:0]   out_org [3],
  output logic signed [W-1:0]   out_head [3],
  output logic signed [W-1:0]   out_t0,
  output rcch_class_t           out_cls,
  output logic signed [2*W+1:0] out_den,
  output logic signed [2*W+2:0] out_nb,
  output logic signed [2*W+2:0] out_nt
);

  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 2;
  localparam int NW = 2 * W + 3;

  localparam logic signed [PW:0]   HALF = {{(PW + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
  localparam logic signed [PW+1:0] SMAX = {{(PW + 3 - W){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [PW+1:0] SMIN = ~SMAX;
  localparam logic signed [W-1:0]  MAXW = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0]  MINW = ~MAXW;

  // point relative to r: sat(o - r + round(p / 2^F))
  function automatic logic signed [W-1:0] rel_pt(input logic signed [W-1:0]  o,
                                                  input logic signed [W-1:0]  r,
                                                  input logic signed [PW-1:0] p);
    logic signed [PW:0]   rp;
    logic signed [PW+1:0] s;
    rp = ((PW + 1)'(p) + HALF) >>> F;
    s  = (PW + 2)'(o) - (PW + 2)'(r) + (PW + 2)'(rp);
    if (s > SMAX) begin
      rel_pt = MAXW;
    end else if (s < SMIN) begin
      rel_pt = MINW;
    end else begin
      rel_pt = s[W-1:0];
    end
  endfunction

  // geometry derived from the registers
  logic signed [PW-1:0] g_ah [3];
  logic signed [PW-1:0] g_ab [3];
  logic signed [PW-1:0] g_at [3];
  logic signed [DW-1:0] dab;
  logic signed [DW-1:0] dat;
  logic signed [W-1:0]  zero_pt;

  assign zero_pt = '0;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      g_ah[i]   <= axis_dir[i] * $signed({1'b0, height});
      top_pt[i] <= rel_pt(base_pt[i], zero_pt, g_ah[i]);
      g_ab[i]   <= axis_dir[i] * base_pt[i];
      g_at[i]   <= axis_dir[i] * top_pt[i];
    end
    radius_sq <= radius * radius;
    dab       <= DW'(g_ab[0]) + DW'(g_ab[1]) + DW'(g_ab[2]);
    dat       <= DW'(g_at[0]) + DW'(g_at[1]) + DW'(g_at[2]);
  end

  // item pipeline
  logic                 v1, v2, v3, v4;
  logic signed [W-1:0]  o1 [3], h1 [3], o2 [3], h2 [3], o3 [3], h3 [3], o4 [3], h4 [3];
  logic signed [W-1:0]  t1, t2, t3, t4;
  logic                 c1, c2, c3, c4;
  logic signed [PW-1:0] ht2 [3], ah2 [3], ao2 [3];
  logic signed [W-1:0]  cb3 [3], ct3 [3];
  logic signed [DW-1:0] den3, aos3, den4;
  logic signed [PW-1:0] pb4 [3], pt4 [3];
  logic signed [NW-1:0] nb4, nt4;
  logic signed [DW-1:0] db4, dt4;
  logic                 side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      o1[i]  <= in_org[i];
      h1[i]  <= in_head[i];
      ht2[i] <= h1[i] * t1;
      ah2[i] <= axis_dir[i] * h1[i];
      ao2[i] <= axis_dir[i] * o1[i];
      o2[i]  <= o1[i];
      h2[i]  <= h1[i];
      cb3[i] <= rel_pt(o2[i], base_pt[i], ht2[i]);
      ct3[i] <= rel_pt(o2[i], top_pt[i], ht2[i]);
      o3[i]  <= o2[i];
      h3[i]  <= h2[i];
      pb4[i] <= axis_dir[i] * cb3[i];
      pt4[i] <= axis_dir[i] * ct3[i];
      o4[i]  <= o3[i];
      h4[i]  <= h3[i];
      out_org[i]  <= o4[i];
      out_head[i] <= h4[i];
    end
    t1 <= in_t0;
    c1 <= in_cone;
    t2 <= t1;
    c2 <= c1;
    den3 <= DW'(ah2[0]) + DW'(ah2[1]) + DW'(ah2[2]);
    aos3 <= DW'(ao2[0]) + DW'(ao2[1]) + DW'(ao2[2]);
    t3 <= t2;
    c3 <= c2;
    nb4  <= NW'(dab) - NW'(aos3);
    nt4  <= NW'(dat) - NW'(aos3);
    den4 <= den3;
    t4 <= t3;
    c4 <= c3;
    out_t0           <= t4;
    out_den          <= den4;
    out_nb           <= nb4;
    out_nt           <= nt4;
    out_cls.side_hit <= side4;
    out_cls.den_zero <= (den4 == '0);
    out_cls.cone     <= c4;
  end

  // side hit: t0 > 0, above the base plane and below the top plane
  always_comb begin
    db4   = DW'(pb4[0]) + DW'(pb4[1]) + DW'(pb4[2]);
    dt4   = DW'(pt4[0]) + DW'(pt4[1]) + DW'(pt4[2]);
    side4 = !t4[W-1] && (t4 != '0) && !db4[DW-1] && (db4 != '0) && dt4[DW-1];
  end

endmodule

// ----- hdl/rcch_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcch_back
// cap distance division, nearer-cap choice, disc radius test, result word
// ----------------------------------------------------------------------------
module rcch_back
  import rcch_pkg::*;
#(
  parameter int W = DEF_COORD_WIDTH,
  parameter int F = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   in_org [3],
  input  logic signed [W-1:0]   in_head [3],
  input  logic signed [W-1:0]   in_t0,
  input  rcch_class_t           in_cls,
  input  logic signed [2*W+1:0] in_den,
  input  logic signed [2*W+2:0] in_nb,
  input  logic signed [2*W+2:0] in_nt,
  input  logic signed [W-1:0]   base_pt [3],
  input  logic signed [W-1:0]   top_pt [3],
  input  logic        [2*W-3:0] radius_sq,
  output logic                  out_valid,
  output rcch_flags_t           out_flags,
  output logic signed [W-1:0]   out_dist
);

  localparam int PW  = 2 * W;
  localparam int DW  = 2 * W + 2;
  localparam int NW  = 2 * W + 3;
  localparam int RW  = 3 * W + 3 + F;
  localparam int PAY = 7 * W;

  localparam logic signed [PW:0]   HALF = {{(PW + 1 - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
  localparam logic signed [PW+1:0] SMAX = {{(PW + 3 - W){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [PW+1:0] SMIN = ~SMAX;
  localparam logic signed [W-1:0]  MAXW = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0]  MINW = ~MAXW;

  typedef struct packed {
    logic neg_b;
    logic neg_t;
    logic ov_b;
    logic ov_t;
  } div_flags_t;

  function automatic logic signed [W-1:0] rel_pt(input logic signed [W-1:0]  o,
                                                  input logic signed [W-1:0]  r,
                                                  input logic signed [PW-1:0] p);
    logic signed [PW:0]   rp;
    logic signed [PW+1:0] s;
    rp = ((PW + 1)'(p) + HALF) >>> F;
    s  = (PW + 2)'(o) - (PW + 2)'(r) + (PW + 2)'(rp);
    if (s > SMAX) begin
      rel_pt = MAXW;
    end else if (s < SMIN) begin
      rel_pt = MINW;
    end else begin
      rel_pt = s[W-1:0];
    end
  endfunction

  // saturate an unsigned quotient with its sign
  function automatic logic signed [W-1:0] sat_q(input logic [W-1:0] q,
                                                 input logic ov, input logic neg);
    logic big;
    big = ov || q[W-1];
    if (neg) begin
      sat_q = big ? MINW : W'(0) - q;
    end else begin
      sat_q = big ? MAXW : q;
    end
  endfunction

  // stage 0: registered word from the queue
  logic                 v0;
  logic [PAY-1:0]       pay0;
  rcch_class_t          cls0;
  logic signed [DW-1:0] den0;
  logic signed [NW-1:0] nb0, nt0;

  always_ff @(posedge clk) begin
    pay0 <= {in_t0, in_head[2], in_head[1], in_head[0], in_org[2], in_org[1], in_org[0]};
    cls0 <= in_cls;
    den0 <= in_den;
    nb0  <= in_nb;
    nt0  <= in_nt;
  end

  // stage 1: magnitudes and quotient signs
  logic [NW-1:0]  nbm, ntm;
  logic [DW-1:0]  dm;
  logic           v1;
  logic [RW-1:0]  nb1, nt1;
  logic [DW-1:0]  d1;
  logic           negb1, negt1;
  logic [PAY-1:0] pay1;
  rcch_class_t    cls1;

  always_comb begin
    nbm = nb0[NW-1] ? -nb0 : nb0;
    ntm = nt0[NW-1] ? -nt0 : nt0;
    dm  = den0[DW-1] ? -den0 : den0;
  end

  always_ff @(posedge clk) begin
    nb1   <= RW'({nbm, {F{1'b0}}});
    nt1   <= RW'({ntm, {F{1'b0}}});
    d1    <= dm;
    negb1 <= nb0[NW-1] ^ den0[DW-1];
    negt1 <= nt0[NW-1] ^ den0[DW-1];
    pay1  <= pay0;
    cls1  <= cls0;
  end

  // division pipeline, one quotient bit a stage, entry 0 carries overflow
  logic             dv_v   [W+1];
  logic [RW-1:0]    dv_rb  [W+1];
  logic [RW-1:0]    dv_rt  [W+1];
  logic [W-1:0]     dv_qb  [W+1];
  logic [W-1:0]     dv_qt  [W+1];
  logic [DW-1:0]    dv_d   [W+1];
  div_flags_t       dv_fl  [W+1];
  logic [PAY-1:0]   dv_pay [W+1];
  rcch_class_t      dv_cls [W+1];

  always_ff @(posedge clk) begin
    dv_rb[0]       <= nb1;
    dv_rt[0]       <= nt1;
    dv_qb[0]       <= '0;
    dv_qt[0]       <= '0;
    dv_d[0]        <= d1;
    dv_fl[0].neg_b <= negb1;
    dv_fl[0].neg_t <= negt1;
    dv_fl[0].ov_b  <= nb1 >= (RW'(d1) << W);
    dv_fl[0].ov_t  <= nt1 >= (RW'(d1) << W);
    dv_pay[0]      <= pay1;
    dv_cls[0]      <= cls1;
  end

  for (genvar j = 0; j < W; j++) begin : g_div
    localparam int K = W - 1 - j;
    logic [RW-1:0] dsh;
    assign dsh = RW'(dv_d[j]) << K;
    always_ff @(posedge clk) begin
      if (dv_rb[j] >= dsh) begin
        dv_rb[j+1] <= dv_rb[j] - dsh;
        dv_qb[j+1] <= {dv_qb[j][W-2:0], 1'b1};
      end else begin
        dv_rb[j+1] <= dv_rb[j];
        dv_qb[j+1] <= {dv_qb[j][W-2:0], 1'b0};
      end
      if (dv_rt[j] >= dsh) begin
        dv_rt[j+1] <= dv_rt[j] - dsh;
        dv_qt[j+1] <= {dv_qt[j][W-2:0], 1'b1};
      end else begin
        dv_rt[j+1] <= dv_rt[j];
        dv_qt[j+1] <= {dv_qt[j][W-2:0], 1'b0};
      end
      dv_d[j+1]   <= dv_d[j];
      dv_fl[j+1]  <= dv_fl[j];
      dv_pay[j+1] <= dv_pay[j];
      dv_cls[j+1] <= dv_cls[j];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end
  end

  // saturate cap distances
  logic                vs;
  logic signed [W-1:0] tbs, tts;
  logic [PAY-1:0]      pays;
  rcch_class_t         clss;

  always_ff @(posedge clk) begin
    tbs  <= sat_q(dv_qb[W], dv_fl[W].ov_b, dv_fl[W].neg_b);
    tts  <= sat_q(dv_qt[W], dv_fl[W].ov_t, dv_fl[W].neg_t);
    pays <= dv_pay[W];
    clss <= dv_cls[W];
  end

  // choose the nearer positive cap
  logic                s_base, s_top;
  logic signed [W-1:0] s_org [3], s_head [3];
  logic                ve, cape, sidee;
  logic signed [W-1:0] te, t0e;
  logic signed [W-1:0] refe [3], orge [3], heade [3];
  surf_t               surfe;

  always_comb begin
    s_base = !clss.cone && (tbs < tts) && !tbs[W-1] && (tbs != '0);
    s_top  = !s_base && (tts < tbs) && !tts[W-1] && (tts != '0);
    for (int i = 0; i < 3; i++) begin
      s_org[i]  = pays[i*W +: W];
      s_head[i] = pays[(3 + i)*W +: W];
    end
  end

  always_ff @(posedge clk) begin
    cape  <= !clss.side_hit && !clss.den_zero && (s_base || s_top);
    sidee <= clss.side_hit;
    te    <= s_base ? tbs : tts;
    t0e   <= pays[6*W +: W];
    surfe <= s_base ? SURF_BASE : SURF_TOP;
    for (int i = 0; i < 3; i++) begin
      refe[i]  <= s_base ? base_pt[i] : top_pt[i];
      orge[i]  <= s_org[i];
      heade[i] <= s_head[i];
    end
  end

  // cap point and squared distance from the cap center
  logic                 vm, vc, vq;
  logic signed [PW-1:0] htm [3];
  logic signed [W-1:0]  refm [3], orgm [3];
  logic signed [W-1:0]  cc [3];
  logic signed [PW-1:0] sq [3];
  logic                 capm, capc, capq, sidem, sidec, sideq;
  logic signed [W-1:0]  tm, tc, tq, t0m, t0c, t0q;
  surf_t                surfm, surfc, surfq;
  logic [DW-1:0]        sum_sq;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      htm[i]  <= heade[i] * te;
      refm[i] <= refe[i];
      orgm[i] <= orge[i];
      cc[i]   <= rel_pt(orgm[i], refm[i], htm[i]);
      sq[i]   <= cc[i] * cc[i];
    end
    capm  <= cape;
    capc  <= capm;
    capq  <= capc;
    sidem <= sidee;
    sidec <= sidem;
    sideq <= sidec;
    tm    <= te;
    tc    <= tm;
    tq    <= tc;
    t0m   <= t0e;
    t0c   <= t0m;
    t0q   <= t0c;
    surfm <= surfe;
    surfc <= surfm;
    surfq <= surfc;
  end

  assign sum_sq = DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]);

  always_ff @(posedge clk) begin
    if (sideq) begin
      out_flags.hit     <= 1'b1;
      out_flags.surface <= SURF_SIDE;
      out_dist          <= t0q;
    end else if (capq && (DW'(radius_sq) >= sum_sq)) begin
      out_flags.hit     <= 1'b1;
      out_flags.surface <= surfq;
      out_dist          <= tq;
    end else begin
      out_flags.hit     <= 1'b0;
      out_flags.surface <= SURF_SIDE;
      out_dist          <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      dv_v[0]   <= 1'b0;
      vs        <= 1'b0;
      ve        <= 1'b0;
      vm        <= 1'b0;
      vc        <= 1'b0;
      vq        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0        <= in_valid;
      v1        <= v0;
      dv_v[0]   <= v1;
      vs        <= dv_v[W];
      ve        <= vs;
      vm        <= ve;
      vc        <= vm;
      vq        <= vc;
      out_valid <= vq;
    end
  end

endmodule

// ----- hdl/ray_capped_cylinder_hit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_capped_cylinder_hit_core
// final hit selection of a ray against a capped cylinder or cone
// ----------------------------------------------------------------------------
// One ray word is accepted per clock while full is low and one result word
// leaves per clock while a word is shown and popped. Most of the depth is
// the back end's bit-per-stage divider for the two cap plane distances. The
// front end (5 stages) checks the side hit and forms the cap numerators; a
// 16 entry queue then feeds the back end, which divides, picks the nearer
// positive cap (never the base cap on a cone) and tests the disc radius.
// Both halves are metered by credit counters, so full only rises when the
// middle queue is taken up or a register write settles. After any register
// write, full stays high while the top point and the axis projections are
// recomputed. Coordinates and distances are signed fixed point with
// FRAC_BITS fraction bits; a miss reads hit 0, distance 0, surface side.
// ----------------------------------------------------------------------------
module ray_capped_cylinder_hit_core
  import rcch_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // ray words
  input  logic                   push,
  output logic                   full,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] heading_x,
  input  logic signed [COORD_WIDTH-1:0] heading_y,
  input  logic signed [COORD_WIDTH-1:0] heading_z,
  input  logic signed [COORD_WIDTH-1:0] side_t_first,
  input  logic signed [COORD_WIDTH-1:0] side_t_second,
  input  logic                   is_cone,
  // result words
  output logic                   empty,
  input  logic                   pop,
  output logic                   hit,
  output logic signed [COORD_WIDTH-1:0] distance,
  output logic [1:0]             surface,
  // register writes
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 2;
  localparam int NW = 2 * W + 3;

  localparam logic [2:0] REG_BASE_X = 3'd0;
  localparam logic [2:0] REG_BASE_Y = 3'd1;
  localparam logic [2:0] REG_BASE_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_X = 3'd3;
  localparam logic [2:0] REG_AXIS_Y = 3'd4;
  localparam logic [2:0] REG_AXIS_Z = 3'd5;
  localparam logic [2:0] REG_HEIGHT = 3'd6;
  localparam logic [2:0] REG_RADIUS = 3'd7;

  localparam int SETTLE_CYCLES = 4;
  localparam int SCW           = $clog2(SETTLE_CYCLES + 1);

  // credit limits: queue memory plus its head register
  localparam int MID_DEPTH = 16;
  localparam int MID_CAP   = MID_DEPTH + 1;
  localparam int MCW       = $clog2(MID_CAP + 1);
  localparam int OUT_DEPTH = 2 ** $clog2(W + 16);
  localparam int OUT_CAP   = OUT_DEPTH + 1;
  localparam int OCW       = $clog2(OUT_CAP + 1);

  // queue word layout
  localparam int CLS_W  = $bits(rcch_class_t);
  localparam int FLG_W  = $bits(rcch_flags_t);
  localparam int O_HEAD = 3 * W;
  localparam int O_T0   = 6 * W;
  localparam int O_DEN  = 7 * W;
  localparam int O_NB   = O_DEN + DW;
  localparam int O_NT   = O_NB + NW;
  localparam int O_CLS  = O_NT + NW;
  localparam int MID_W  = O_CLS + CLS_W;
  localparam int OUT_W  = W + FLG_W;

  // register file
  logic signed [W-1:0] base_r [3];
  logic signed [W-1:0] axis_r [3];
  logic        [W-2:0] height_r;
  logic        [W-2:0] radius_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_r[0] <= '0;
      base_r[1] <= '0;
      base_r[2] <= '0;
      axis_r[0] <= '0;
      axis_r[1] <= W'(1) << FRAC_BITS;
      axis_r[2] <= '0;
      height_r  <= (W - 1)'(1) << FRAC_BITS;
      radius_r  <= (W - 1)'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_X: base_r[0] <= cfg_data;
        REG_BASE_Y: base_r[1] <= cfg_data;
        REG_BASE_Z: base_r[2] <= cfg_data;
        REG_AXIS_X: axis_r[0] <= cfg_data;
        REG_AXIS_Y: axis_r[1] <= cfg_data;
        REG_AXIS_Z: axis_r[2] <= cfg_data;
        REG_HEIGHT: height_r  <= cfg_data[W-2:0];
        REG_RADIUS: radius_r  <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // hold off rays while derived geometry catches up with a write
  logic [SCW-1:0] settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '0;
    end else if (cfg_we) begin
      settle <= SCW'(SETTLE_CYCLES);
    end else if (settle != '0) begin
      settle <= settle - SCW'(1);
    end
  end

  // handshakes and credits
  logic           accept;
  logic           mid_pop;
  logic           mid_empty;
  logic           out_pop;
  logic [MCW-1:0] mid_used;
  logic [OCW-1:0] out_used;

  assign full    = (settle != '0) || (mid_used == MCW'(MID_CAP));
  assign accept  = push && !full;
  assign mid_pop = !mid_empty && (out_used != OCW'(OUT_CAP));
  assign out_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_used <= '0;
      out_used <= '0;
    end else begin
      mid_used <= mid_used + MCW'(accept) - MCW'(mid_pop);
      out_used <= out_used + OCW'(mid_pop) - OCW'(out_pop);
    end
  end

  // front end
  logic signed [W-1:0]   org_a [3];
  logic signed [W-1:0]   head_a [3];
  logic signed [W-1:0]   top_pt [3];
  logic        [2*W-3:0] radius_sq;
  logic                  f_valid;
  logic signed [W-1:0]   f_org [3];
  logic signed [W-1:0]   f_head [3];
  logic signed [W-1:0]   f_t0;
  rcch_class_t           f_cls;
  logic signed [DW-1:0]  f_den;
  logic signed [NW-1:0]  f_nb;
  logic signed [NW-1:0]  f_nt;

  assign org_a[0]  = origin_x;
  assign org_a[1]  = origin_y;
  assign org_a[2]  = origin_z;
  assign head_a[0] = heading_x;
  assign head_a[1] = heading_y;
  assign head_a[2] = heading_z;

  rcch_front #(
    .W (W),
    .F (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_org    (org_a),
    .in_head   (head_a),
    .in_t0     (side_t_first),
    .in_cone   (is_cone),
    .base_pt   (base_r),
    .axis_dir  (axis_r),
    .height    (height_r),
    .radius    (radius_r),
    .top_pt    (top_pt),
    .radius_sq (radius_sq),
    .out_valid (f_valid),
    .out_org   (f_org),
    .out_head  (f_head),
    .out_t0    (f_t0),
    .out_cls   (f_cls),
    .out_den   (f_den),
    .out_nb    (f_nb),
    .out_nt    (f_nt)
  );

  // queue between the halves
  logic [MID_W-1:0]     mid_din;
  logic [MID_W-1:0]     mid_dout;
  logic signed [W-1:0]  m_org [3];
  logic signed [W-1:0]  m_head [3];
  logic signed [W-1:0]  m_t0;
  rcch_class_t          m_cls;
  logic signed [DW-1:0] m_den;
  logic signed [NW-1:0] m_nb;
  logic signed [NW-1:0] m_nt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mid_din[i*W +: W]          = f_org[i];
      mid_din[O_HEAD + i*W +: W] = f_head[i];
      m_org[i]  = mid_dout[i*W +: W];
      m_head[i] = mid_dout[O_HEAD + i*W +: W];
    end
    mid_din[O_T0 +: W]      = f_t0;
    mid_din[O_DEN +: DW]    = f_den;
    mid_din[O_NB +: NW]     = f_nb;
    mid_din[O_NT +: NW]     = f_nt;
    mid_din[O_CLS +: CLS_W] = f_cls;
    m_t0  = mid_dout[O_T0 +: W];
    m_den = mid_dout[O_DEN +: DW];
    m_nb  = mid_dout[O_NB +: NW];
    m_nt  = mid_dout[O_NT +: NW];
    m_cls = rcch_class_t'(mid_dout[O_CLS +: CLS_W]);
  end

  rcch_fifo #(
    .DATA_W (MID_W),
    .DEPTH  (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid),
    .din   (mid_din),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  // back end
  logic                b_valid;
  rcch_flags_t         b_flags;
  logic signed [W-1:0] b_dist;

  rcch_back #(
    .W (W),
    .F (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_pop),
    .in_org    (m_org),
    .in_head   (m_head),
    .in_t0     (m_t0),
    .in_cls    (m_cls),
    .in_den    (m_den),
    .in_nb     (m_nb),
    .in_nt     (m_nt),
    .base_pt   (base_r),
    .top_pt    (top_pt),
    .radius_sq (radius_sq),
    .out_valid (b_valid),
    .out_flags (b_flags),
    .out_dist  (b_dist)
  );

  // result queue
  logic [OUT_W-1:0] out_dout;
  rcch_flags_t      out_fl;

  rcch_fifo #(
    .DATA_W (OUT_W),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (b_valid),
    .din   ({b_flags, b_dist}),
    .pop   (out_pop),
    .dout  (out_dout),
    .empty (empty)
  );

  assign out_fl   = rcch_flags_t'(out_dout[W +: FLG_W]);
  assign hit      = out_fl.hit;
  assign surface  = out_fl.surface;
  assign distance = out_dout[W-1:0];

`ifndef SYNTHESIS
  // a register write must block rays while the geometry settles
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst) cfg_we |=> full)
    else $error("ray accepted right after a register write");

  // credits never run past the queue capacity
  a_mid_cap: assert property (@(posedge clk) disable iff (rst)
    mid_used <= MCW'(MID_CAP))
    else $error("front credit count overflow");

  a_out_cap: assert property (@(posedge clk) disable iff (rst)
    out_used <= OCW'(OUT_CAP))
    else $error("back credit count overflow");

  // a shown result must be accounted for by a credit
  a_out_owned: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_used != '0))
    else $error("result word without a credit");

  // no credits in use means nothing waits between the halves
  a_mid_idle: assert property (@(posedge clk) disable iff (rst)
    (mid_used == '0) |-> mid_empty)
    else $error("queue word without a credit");
`endif

endmodule

// ----- tb/sv/ray_capped_cylinder_hit_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_capped_cylinder_hit_core_tb
// self-checking bench for the capped cylinder / cone hit core
// ----------------------------------------------------------------------------
// A table of directed rays (caps, side, cone, parallel ray, field extremes)
// runs first, then random rays over several register settings. Each result
// word is matched to its typed row or a bit-exact fixed point predictor kept
// here. Both queue sides idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module ray_capped_cylinder_hit_core_tb
  import rcch_pkg::*;
;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int Q1 = 65536;           // 1.0 in Q16.16
  localparam int N_PHASES = 11;
  localparam int RAYS_PER_PHASE = 112;

  // register indexes
  typedef enum logic [2:0] {
    REG_BASE_X, REG_BASE_Y, REG_BASE_Z,
    REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z,
    REG_HEIGHT, REG_RADIUS
  } reg_idx_t;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t ox, oy, oz, hx, hy, hz, t0, t1;
    logic   cone;
  } ray_t;

  typedef struct {
    logic   hit;
    coord_t hit_dist;
    surf_t  surf;
  } hit_res_t;

  typedef struct {
    ray_t     ray;
    bit       typed;
    hit_res_t want;
  } row_t;

  localparam wide_t WIDE_MAX = (wide_t'(1) <<< 126) - 1;
  localparam wide_t C_MAX = wide_t'(2147483647);
  localparam wide_t C_MIN = -(wide_t'(1) <<< 31);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  coord_t origin_x = '0, origin_y = '0, origin_z = '0;
  coord_t heading_x = '0, heading_y = '0, heading_z = '0;
  coord_t side_t_first = '0, side_t_second = '0;
  logic is_cone = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic hit;
  coord_t distance;
  logic [1:0] surface;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  // shadow registers for the predictor
  coord_t sh_base [3];
  coord_t sh_axis [3];
  logic [30:0] sh_height, sh_radius;

  hit_res_t pending_hits [$];
  row_t     rows [$];
  int       n_errors = 0;
  bit       no_idle = 1'b0;
  int       pop_stall = 0;

  always #4 clk = ~clk;

  ray_capped_cylinder_hit_core dut (
    .clk, .rst, .push, .full,
    .origin_x, .origin_y, .origin_z, .heading_x, .heading_y, .heading_z,
    .side_t_first, .side_t_second, .is_cone,
    .empty, .pop, .hit, .distance, .surface,
    .cfg_we, .cfg_index, .cfg_data
  );

  // ---------------------------------------------------------------- predictor

  function automatic wide_t wclamp(wide_t a);
    if (a > WIDE_MAX) return WIDE_MAX;
    if (a < -WIDE_MAX) return -WIDE_MAX;
    return a;
  endfunction

  // round to nearest (half up), drop the fraction, saturate to a coordinate
  function automatic coord_t round_sat(wide_t a);
    wide_t s;
    s = (a + (wide_t'(1) <<< (FB - 1))) >>> FB;
    if (s > C_MAX) return coord_t'(C_MAX);
    if (s < C_MIN) return coord_t'(C_MIN);
    return coord_t'(s);
  endfunction

  function automatic wide_t dot3(coord_t a [3], coord_t b [3]);
    wide_t acc;
    acc = wclamp(wide_t'(a[0]) * wide_t'(b[0]));
    acc = wclamp(acc + wclamp(wide_t'(a[1]) * wide_t'(b[1])));
    acc = wclamp(acc + wclamp(wide_t'(a[2]) * wide_t'(b[2])));
    return acc;
  endfunction

  // point on the ray at distance t, relative to ref
  function automatic void point_at(coord_t org [3], coord_t head [3], coord_t ref_pt [3],
                                   coord_t t, output coord_t c [3]);
    wide_t acc;
    for (int i = 0; i < 3; i++) begin
      acc = wclamp(wclamp(wide_t'(org[i]) <<< FB) - wclamp(wide_t'(ref_pt[i]) <<< FB));
      acc = wclamp(acc + wclamp(wide_t'(head[i]) * wide_t'(t)));
      c[i] = round_sat(acc);
    end
  endfunction

  // truncating fixed point divide, saturated
  function automatic coord_t plane_dist(wide_t num, wide_t den);
    logic [159:0] n, d, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? 160'(-num) : 160'(num);
    d = (den < 0) ? 160'(-den) : 160'(den);
    q = (n << FB) / d;
    if (neg) begin
      if (q >= 160'h8000_0000) return coord_t'(C_MIN);
      return -coord_t'(q[31:0]);
    end
    if (q > 160'h7FFF_FFFF) return coord_t'(C_MAX);
    return coord_t'(q[31:0]);
  endfunction

  function automatic hit_res_t predict_hit(ray_t r);
    hit_res_t res;
    coord_t org [3], head [3], top [3], c [3], ct [3];
    coord_t tb, tt;
    wide_t db, dt, den, ao, r2;
    res = '{1'b0, '0, SURF_SIDE};
    org = '{r.ox, r.oy, r.oz};
    head = '{r.hx, r.hy, r.hz};
    for (int i = 0; i < 3; i++)
      top[i] = round_sat(wclamp(wclamp(wide_t'(sh_base[i]) <<< FB)
                                + wclamp(wide_t'(sh_axis[i]) * wide_t'({1'b0, sh_height}))));
    // side surface first
    if (r.t0 > 0) begin
      point_at(org, head, sh_base, r.t0, c);
      point_at(org, head, top, r.t0, ct);
      db = dot3(sh_axis, c);
      dt = dot3(sh_axis, ct);
      if (db > 0 && dt < 0) return '{1'b1, r.t0, SURF_SIDE};
    end
    den = dot3(sh_axis, head);
    if (den == 0) return res;
    ao = dot3(sh_axis, org);
    tb = plane_dist(wclamp(dot3(sh_axis, sh_base) - ao), den);
    tt = plane_dist(wclamp(dot3(sh_axis, top) - ao), den);
    r2 = wide_t'({1'b0, sh_radius}) * wide_t'({1'b0, sh_radius});
    if (!r.cone && tb < tt && tb > 0) begin
      point_at(org, head, sh_base, tb, c);
      if (dot3(c, c) <= r2) res = '{1'b1, tb, SURF_BASE};
    end else if (tt < tb && tt > 0) begin
      point_at(org, head, top, tt, c);
      if (dot3(c, c) <= r2) res = '{1'b1, tt, SURF_TOP};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx) inside
      REG_BASE_X, REG_BASE_Y, REG_BASE_Z: sh_base[idx - REG_BASE_X] = data;
      REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z: sh_axis[idx - REG_AXIS_X] = data;
      REG_HEIGHT: sh_height = data[30:0];
      REG_RADIUS: sh_radius = data[30:0];
      default: ;
    endcase
  endtask

  // hands one ray word over; expectation queued at the accepting edge
  task automatic push_ray(ray_t r, bit typed, hit_res_t want);
    origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
    heading_x <= r.hx; heading_y <= r.hy; heading_z <= r.hz;
    side_t_first <= r.t0; side_t_second <= r.t1;
    is_cone <= r.cone;
    push <= 1'b1;
    do @(posedge clk); while (full);
    pending_hits.push_back(typed ? want : predict_hit(r));
  endtask

  task automatic sender_gap();
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // waits until every expected word is back, then lets the pipe settle
  task automatic drain();
    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic coord_t near_q(int units);
    return coord_t'($urandom_range(0, 2 * units * Q1)) - coord_t'(units * Q1);
  endfunction

  function automatic ray_t make_ray(int ox, int oy, int oz, int hx, int hy, int hz,
                                    int t0, int t1, bit cone);
    return '{coord_t'(ox), coord_t'(oy), coord_t'(oz), coord_t'(hx), coord_t'(hy),
             coord_t'(hz), coord_t'(t0), coord_t'(t1), cone};
  endfunction

  task automatic add_row(ray_t r, bit typed, logic h, int d, surf_t s);
    rows.push_back('{r, typed, '{h, coord_t'(d), s}});
  endtask

  // a ray aimed roughly at the body, random content
  function automatic ray_t shaped_ray();
    ray_t r;
    r.ox = near_q(4); r.oy = near_q(4); r.oz = near_q(4);
    case ($urandom_range(0, 3))
      0: begin r.hx = '0; r.hy = '0; r.hz = '0; end
      default: begin r.hx = near_q(1); r.hy = near_q(1); r.hz = near_q(1); end
    endcase
    // aligned heading now and then so cap paths come up often
    if ($urandom_range(0, 2) == 0) begin
      r.hx = '0; r.hz = '0; r.hy = ($urandom_range(0, 1) ? Q1 : -Q1);
      for (int i = 0; i < 3; i++)
        if (sh_axis[i] != 0) begin
          r.hx = (i == 0) ? r.hy : '0;
          r.hz = (i == 2) ? r.hy : '0;
          if (i != 1) r.hy = '0;
        end
    end
    r.t0 = ($urandom_range(0, 4) == 0) ? coord_t'($urandom) : near_q(6);
    r.t1 = coord_t'($urandom);
    r.cone = $urandom_range(0, 1);
    return r;
  endfunction

  function automatic ray_t noise_ray();
    return '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), coord_t'($urandom), 1'($urandom)};
  endfunction

  task automatic set_shape(int mode);
    int ax;
    coord_t u;
    case (mode)
      // field extremes, height and radius with the unused top bit set
      8: begin
        write_reg(REG_BASE_X, 32'h7FFF_FFFF); write_reg(REG_BASE_Y, 32'h8000_0000);
        write_reg(REG_BASE_Z, 32'h7FFF_FFFF); write_reg(REG_AXIS_X, 32'h8000_0000);
        write_reg(REG_AXIS_Y, 32'h7FFF_FFFF); write_reg(REG_AXIS_Z, 32'h8000_0000);
        write_reg(REG_HEIGHT, 32'hFFFF_FFFF); write_reg(REG_RADIUS, 32'hFFFF_FFFF);
      end
      // degenerate: zero axis, zero height, zero radius
      9: begin
        write_reg(REG_BASE_X, 32'h8000_0000); write_reg(REG_BASE_Y, '0);
        write_reg(REG_BASE_Z, 32'h8000_0000); write_reg(REG_AXIS_X, '0);
        write_reg(REG_AXIS_Y, '0); write_reg(REG_AXIS_Z, '0);
        write_reg(REG_HEIGHT, 32'h8000_0000); write_reg(REG_RADIUS, '0);
      end
      default: begin
        ax = $urandom_range(0, 2);
        u = $urandom_range(0, 1) ? Q1 : -Q1;
        write_reg(REG_BASE_X, near_q(1)); write_reg(REG_BASE_Y, near_q(1));
        write_reg(REG_BASE_Z, near_q(1));
        // unit axis mostly, a skewed one now and then
        write_reg(REG_AXIS_X, (ax == 0) ? u : (mode == 5 ? near_q(1) : '0));
        write_reg(REG_AXIS_Y, (ax == 1) ? u : '0);
        write_reg(REG_AXIS_Z, (ax == 2) ? u : (mode == 5 ? near_q(1) : '0));
        write_reg(REG_HEIGHT, {1'($urandom), 31'($urandom_range(0, 4 * Q1))});
        write_reg(REG_RADIUS, {1'($urandom), 31'($urandom_range(0, 3 * Q1))});
      end
    endcase
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    hit_res_t want;
    if (!rst && pop && !empty) begin
      if (pending_hits.size() == 0) begin
        report("unexpected word, distance", 64'(distance), '0);
      end else begin
        want = pending_hits.pop_front();
        if (hit !== want.hit) report("hit", 64'(hit), 64'(want.hit));
        if (distance !== want.hit_dist)
          report("distance", 64'(distance), 64'(want.hit_dist));
        if (surface !== want.surf) report("surface", 64'(surface), 64'(want.surf));
      end
    end
    // consumer stalls in bursts
    if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      pop <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      pop_stall <= $urandom_range(0, 11);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    hit_res_t nohit;
    nohit = '{1'b0, '0, SURF_SIDE};
    sh_base = '{0, 0, 0};
    sh_axis = '{0, Q1, 0};
    sh_height = 31'(Q1);
    sh_radius = 31'(Q1);

    // directed rows, default shape: unit cylinder along y from 0 to 1
    // up the axis from below: base cap at 2.0
    add_row(make_ray(0, -2*Q1, 0, 0, Q1, 0, 0, 0, 0), 1, 1, 2*Q1, SURF_BASE);
    // same ray on a cone: base skipped, top is farther, miss
    add_row(make_ray(0, -2*Q1, 0, 0, Q1, 0, 0, 0, 1), 1, 0, 0, SURF_SIDE);
    // parallel to the caps, no side distance
    add_row(make_ray(0, Q1/2, 0, Q1, 0, 0, 0, 0, 0), 1, 0, 0, SURF_SIDE);
    // side hit inside the body
    add_row(make_ray(-2*Q1, Q1/2, 0, Q1, 0, 0, Q1, 0, 0), 1, 1, Q1, SURF_SIDE);
    // most negative side distance, parallel ray: miss
    add_row(make_ray(-2*Q1, Q1/2, 0, Q1, 0, 0, 32'h8000_0000, -1, 0), 1, 0, 0, SURF_SIDE);
    // largest side distance still lies between the planes
    add_row(make_ray(-2*Q1, Q1/2, 0, Q1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1),
            1, 1, 32'h7FFF_FFFF, SURF_SIDE);
    // down from above: top cap at 2.0, cylinder and cone
    add_row(make_ray(0, 3*Q1, 0, 0, -Q1, 0, 0, 0, 0), 1, 1, 2*Q1, SURF_TOP);
    add_row(make_ray(0, 3*Q1, 0, 0, -Q1, 0, 0, 0, 1), 1, 1, 2*Q1, SURF_TOP);
    // nearer cap outside the radius: no second try
    add_row(make_ray(5*Q1, -2*Q1, 0, 0, Q1, 0, 0, 0, 0), 1, 0, 0, SURF_SIDE);
    // both caps behind the origin
    add_row(make_ray(0, 3*Q1, 0, 0, Q1, 0, 0, 0, 0), 1, 0, 0, SURF_SIDE);
    // side distance positive but the point is past the top, falls to the caps
    add_row(make_ray(0, 3*Q1, 0, 0, -Q1, 0, Q1/2, 0, 0), 0, 0, 0, SURF_SIDE);
    // field extremes, predicted
    add_row(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1),
            0, 0, 0, SURF_SIDE);
    add_row(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0),
            0, 0, 0, SURF_SIDE);
    add_row(make_ray(0, 32'h8000_0000, 0, 0, 1, 0, 1, -1, 0), 0, 0, 0, SURF_SIDE);
    add_row(make_ray(0, 32'h7FFF_FFFF, 0, 0, -1, 0, -1, 0, 1), 0, 0, 0, SURF_SIDE);
    add_row(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, 1), 0, 0, 0, SURF_SIDE);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      push_ray(rows[i].ray, rows[i].typed, rows[i].want);
      sender_gap();
    end
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      // register writes only with the pipe empty
      if (p > 0) begin
        drain();
        set_shape(p == N_PHASES - 1 ? 1 : p);
        drain();
      end
      no_idle = (p == N_PHASES - 1);
      for (int k = 0; k < RAYS_PER_PHASE; k++) begin
        if ($urandom_range(0, 3) == 0) push_ray(noise_ray(), 0, nohit);
        else push_ray(shaped_ray(), 0, nohit);
        sender_gap();
      end
      // sender holds off once until every word is back
      if (p == 3) drain();
    end

    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rcch_pkg.sv
hdl/rcch_fifo.sv
hdl/rcch_front.sv
hdl/rcch_back.sv
hdl/ray_capped_cylinder_hit_core.sv
tb/sv/ray_capped_cylinder_hit_core_tb.sv
